>>> src/cscalc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscalc_pkg
// shared types and constants of the character stream calculator
// ----------------------------------------------------------------------------
package cscalc_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 8;
    localparam int TOKQ_DEPTH     = 4;
    localparam int DECIMAL_BASE   = 10;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TK_DIGIT = 2'd0,
        TK_OP    = 2'd1,
        TK_EQ    = 2'd2,
        TK_BAD   = 2'd3
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic [3:0]  digit;
        t_op         op;
    } t_token;

    typedef enum logic [2:0] {
        BK_FETCH = 3'd0,
        BK_MUL   = 3'd1,
        BK_DIV   = 3'd2,
        BK_SIGN  = 3'd3,
        BK_DONE  = 3'd4,
        BK_EMIT  = 3'd5
    } t_back_state;

endpackage

>>> src/char_stream_calculator_core.sv
`timescale 1ns / 1ps
// path: a character passes the front stage register and the token queue to the back end; a digit
//   is absorbed at fetch, + and - go to done, * runs the shift-add unit and / the restoring divider
//   and sign step before done; one character per back-end pass, the queue lets input run ahead
// a result is registered at emit once '=' has its operator applied and the output slot is free
// reset: synchronous active low; clears queues, accumulator, operand, pending operator, error flag and machine state
// ----------------------------------------------------------------------------
// char_stream_calculator_core
// left-to-right integer calculator fed by ascii characters, queue style ports
// ----------------------------------------------------------------------------
module char_stream_calculator_core #(
    parameter int DATA_WIDTH = cscalc_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // character requests
    input  logic                          push,
    input  logic [cscalc_pkg::CHAR_W-1:0] i_char_code,
    output logic                          full,
    // result requests
    output logic                          empty,
    input  logic                          pop,
    output logic [cscalc_pkg::VALUE_W-1:0] o_value,
    output logic                          o_failed
);
    import cscalc_pkg::*;

    // front stage to queue
    logic   front_valid;
    t_token front_tok;
    logic   q_full;

    // queue to back end
    logic   q_valid;
    t_token q_tok;
    logic   q_pop;

    // front: classify the character and hold the token for one stage
    cscalc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_code (i_char_code),
        .o_full      (full),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_tok_full  (q_full)
    );

    // short token queue so the front keeps taking requests during long divides
    cscalc_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_tok   (front_tok),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (q_pop)
    );

    // back: arithmetic sequencer with registered result slot
    cscalc_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value     (o_value),
        .o_failed    (o_failed)
    );

endmodule

>>> src/cscalc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscalc_front
// accepts characters, classifies them into tokens and holds one in a stage
// ----------------------------------------------------------------------------
module cscalc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [cscalc_pkg::CHAR_W-1:0] i_char_code,
    output logic                         o_full,
    output logic                         o_tok_valid,
    output cscalc_pkg::t_token           o_tok,
    input  logic                         i_tok_full
);
    import cscalc_pkg::*;

    logic   r_valid;
    t_token r_tok;
    t_token n_tok;
    logic   advance;

    // stage moves when empty or when the queue takes its token
    assign advance     = !r_valid || !i_tok_full;
    assign o_full      = !advance;
    assign o_tok_valid = r_valid;
    assign o_tok       = r_tok;

    always_comb begin
        n_tok.kind  = TK_BAD;
        n_tok.digit = 4'(i_char_code - CH_ZERO);
        n_tok.op    = OP_ADD;
        if (i_char_code inside {[CH_ZERO:CH_NINE]}) begin
            n_tok.kind = TK_DIGIT;
        end else begin
            case (i_char_code)
                CH_PLUS: begin
                    n_tok.kind = TK_OP;
                    n_tok.op   = OP_ADD;
                end
                CH_MINUS: begin
                    n_tok.kind = TK_OP;
                    n_tok.op   = OP_SUB;
                end
                CH_STAR: begin
                    n_tok.kind = TK_OP;
                    n_tok.op   = OP_MUL;
                end
                CH_SLASH: begin
                    n_tok.kind = TK_OP;
                    n_tok.op   = OP_DIV;
                end
                CH_EQ: begin
                    n_tok.kind = TK_EQ;
                end
                default: begin
                    n_tok.kind = TK_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && advance) begin
            r_tok <= n_tok;
        end
    end

endmodule

>>> src/cscalc_tokq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscalc_tokq
// short token queue between the front and the back
// ----------------------------------------------------------------------------
module cscalc_tokq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cscalc_pkg::t_token i_tok,
    output logic               o_full,
    output logic               o_valid,
    output cscalc_pkg::t_token o_tok,
    input  logic               i_pop
);
    import cscalc_pkg::*;

    localparam int PW = $clog2(TOKQ_DEPTH);

    t_token        r_mem [TOKQ_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == (PW+1)'(TOKQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

endmodule

>>> src/cscalc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscalc_back
// executes tokens: operand build, add and subtract, shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module cscalc_back #(
    parameter int DATA_WIDTH = cscalc_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok_valid,
    input  cscalc_pkg::t_token            i_tok,
    output logic                          o_tok_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [cscalc_pkg::VALUE_W-1:0] o_value,
    output logic                          o_failed
);
    import cscalc_pkg::*;

    localparam int CW = $clog2(DATA_WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

    t_back_state           r_state, n_state;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_operand, n_operand;
    t_op                   r_pend, n_pend;
    logic                  r_err, n_err;
    t_token                r_tok, n_tok;
    logic [DATA_WIDTH-1:0] r_ma, n_ma;
    logic [DATA_WIDTH-1:0] r_mb, n_mb;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic                  r_neg, n_neg;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]    r_out_value, n_out_value;
    logic                  r_out_failed, n_out_failed;
    logic [DATA_WIDTH:0]   rem_sh;
    logic                  rem_ge;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
        return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    assign o_empty  = !r_out_valid;
    assign o_value  = r_out_value;
    assign o_failed = r_out_failed;

    // one restoring divide step
    assign rem_sh = {r_rem, r_ma[DATA_WIDTH-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_mb});

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_operand    = r_operand;
        n_pend       = r_pend;
        n_err        = r_err;
        n_tok        = r_tok;
        n_ma         = r_ma;
        n_mb         = r_mb;
        n_rem        = r_rem;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_failed = r_out_failed;
        o_tok_pop    = 1'b0;

        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            BK_FETCH: begin
                if (i_tok_valid) begin
                    o_tok_pop = 1'b1;
                    n_tok     = i_tok;
                    case (i_tok.kind)
                        TK_DIGIT: begin
                            if (!r_err) begin
                                n_operand = DATA_WIDTH'(r_operand * DATA_WIDTH'(DECIMAL_BASE))
                                          + DATA_WIDTH'(i_tok.digit);
                            end
                        end
                        TK_BAD: begin
                            n_err = 1'b1;
                        end
                        default: begin
                            if (r_err) begin
                                if (i_tok.kind == TK_EQ) begin
                                    n_state = BK_EMIT;
                                end
                            end else begin
                                case (r_pend)
                                    OP_ADD: begin
                                        n_acc   = r_acc + r_operand;
                                        n_state = BK_DONE;
                                    end
                                    OP_SUB: begin
                                        n_acc   = r_acc - r_operand;
                                        n_state = BK_DONE;
                                    end
                                    OP_MUL: begin
                                        n_ma    = r_acc;
                                        n_mb    = r_operand;
                                        n_acc   = '0;
                                        n_cnt   = CNT_LAST;
                                        n_state = BK_MUL;
                                    end
                                    default: begin
                                        if (r_operand == '0) begin
                                            n_err   = 1'b1;
                                            n_state = BK_DONE;
                                        end else begin
                                            n_ma    = mag(r_acc);
                                            n_mb    = mag(r_operand);
                                            n_rem   = '0;
                                            n_neg   = r_acc[DATA_WIDTH-1]
                                                    ^ r_operand[DATA_WIDTH-1];
                                            n_cnt   = CNT_LAST;
                                            n_state = BK_DIV;
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            BK_MUL: begin
                if (r_mb[0]) begin
                    n_acc = r_acc + r_ma;
                end
                n_ma  = r_ma << 1;
                n_mb  = r_mb >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DIV: begin
                n_rem = rem_ge ? DATA_WIDTH'(rem_sh - {1'b0, r_mb}) : DATA_WIDTH'(rem_sh);
                n_ma  = {r_ma[DATA_WIDTH-2:0], rem_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = BK_SIGN;
                end
            end
            BK_SIGN: begin
                n_acc   = r_neg ? (~r_ma + 1'b1) : r_ma;
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (r_tok.kind == TK_EQ) begin
                    n_state = BK_EMIT;
                end else begin
                    n_pend    = r_tok.op;
                    n_operand = '0;
                    n_state   = BK_FETCH;
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_err ? '0 : VALUE_W'($signed(r_acc));
                    n_out_failed = r_err;
                    n_acc        = '0;
                    n_operand    = '0;
                    n_pend       = OP_ADD;
                    n_err        = 1'b0;
                    n_state      = BK_FETCH;
                end
            end
            default: begin
                n_state = BK_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_FETCH;
            r_acc       <= '0;
            r_operand   <= '0;
            r_pend      <= OP_ADD;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_operand   <= n_operand;
            r_pend      <= n_pend;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok        <= n_tok;
        r_ma         <= n_ma;
        r_mb         <= n_mb;
        r_rem        <= n_rem;
        r_neg        <= n_neg;
        r_cnt        <= n_cnt;
        r_out_value  <= n_out_value;
        r_out_failed <= n_out_failed;
    end

endmodule

>>> src/cscalc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscalc_checker
// port level checks of the calculator core
// ----------------------------------------------------------------------------
module cscalc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [cscalc_pkg::VALUE_W-1:0] o_value,
    input logic                          o_failed
);
    import cscalc_pkg::*;

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // reset leaves the input side open
    a_reset_open: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // a failed expression reports zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_failed) |-> (o_value == '0))
        else $error("failed result with nonzero value");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_failed)))
        else $error("waiting result changed");

endmodule

bind char_stream_calculator_core cscalc_checker u_cscalc_checker (.*);
